// File: rtl/vgm_pkg.sv
`timescale 1ns / 1ps
// vgm_pkg: shared widths, codes and controller/datapath interface types
// for the volume gradient magnitude block. No dependencies.
package vgm_pkg;

	localparam int SIZE_W    = 9;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int DIFF_W    = 17;
	localparam int G_W       = 23;
	localparam int MUL_W     = 23;
	localparam int PROD_W    = 46;
	localparam int ACC_W     = 47;
	localparam int RAD_W     = 48;
	localparam int ROOT_W    = 24;
	localparam int REM_W     = 27;
	localparam int GRAD_W    = 24;
	localparam int ROOT_STEPS = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO = 3'd5;

	// plane store read selects
	localparam logic [2:0] RD_OLD = 3'd0;
	localparam logic [2:0] RD_XP  = 3'd1;
	localparam logic [2:0] RD_XM  = 3'd2;
	localparam logic [2:0] RD_YP  = 3'd3;
	localparam logic [2:0] RD_YM  = 3'd4;

	typedef struct packed {
		logic       accept;
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       cap;
		logic [2:0] cap_sel;
		logic       wr;
		logic       diff;
		logic       mul;
		logic [1:0] mrow;
		logic [1:0] mterm;
		logic       msq;
		logic       acc;
		logic       rnd;
		logic       root_init;
		logic       root_step;
		logic       load;
	} cmd_t;

	typedef struct packed {
		logic drain_pending;
		logic emit;
		logic zero;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/volume_gradient_magnitude_3d.sv
`timescale 1ns / 1ps
// volume_gradient_magnitude_3d: top level, joins the controller and datapath.
// Depends on vgm_pkg, vgm_ctrl, vgm_datapath, vgm_ram.
//
// Voxels enter on the in_valid/in_ready channel in raster order, x fastest,
// with kind 0; kind 1 drains one pending result of the last plane.
// Results leave on out_valid/out_ready, lagging one plane behind the input;
// the first plane of a volume gives no result.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// One transaction is worked at a time, paced by the single read port of the
// plane store, the shared multiplier and the bit-serial square root. A voxel
// without result only reads and writes the plane store; a voxel on a face
// then loads a zero result; an interior voxel first forms the differences,
// the three rounded matrix products and the root of their squares; a drain
// only loads a zero result.
// A finished result sits in the output register; the next input is taken
// while it waits, and the block stalls only when a new result is ready and
// the output register is still held by the receiver.
// Reset clears position and drain count, sets sizes to 256 and loads a diagonal
// matrix of 4096 (one half, as products are shifted down by 13); the plane store is undefined until written.
module volume_gradient_magnitude_3d import vgm_pkg::*; #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [GRAD_W-1:0]   grad_x,
	output logic signed [GRAD_W-1:0]   grad_y,
	output logic signed [GRAD_W-1:0]   grad_z,
	output logic [ROOT_W-1:0]          magnitude,
	output logic                       last
);

	cmd_t  cmd;
	stat_t stat;

	vgm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.kind    (kind),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	vgm_datapath #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y),
		.MAX_Z(MAX_Z)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.kind     (kind),
		.sample   (sample),
		.cmd      (cmd),
		.stat     (stat),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.grad_x   (grad_x),
		.grad_y   (grad_y),
		.grad_z   (grad_z),
		.magnitude(magnitude),
		.last     (last)
	);

`ifndef ASSERT_OFF
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> grad_x == '0 && grad_y == '0 && grad_z == '0 && magnitude == '0)
		else $error("last result carries a non-zero gradient");

	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && magnitude == '0 |-> grad_x == '0 && grad_y == '0 && grad_z == '0)
		else $error("zero magnitude with non-zero gradient");

	a_voxel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> !in_ready)
		else $error("voxel transaction did not occupy the block");
`endif

endmodule

// File: rtl/vgm_ram.sv
`timescale 1ns / 1ps
// vgm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vgm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/vgm_ctrl.sv
`timescale 1ns / 1ps
// vgm_ctrl: sequencing state machine for one transaction at a time.
// Depends on vgm_pkg.
module vgm_ctrl import vgm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  kind,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_READ  = 4'd1;
	localparam logic [3:0] S_DIFF  = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_ACC   = 4'd4;
	localparam logic [3:0] S_RND   = 4'd5;
	localparam logic [3:0] S_RINIT = 4'd6;
	localparam logic [3:0] S_ROOT  = 4'd7;
	localparam logic [3:0] S_LOAD  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] rr_q, rr_d, tt_q, tt_d;
	logic       sq_q, sq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rr_q    <= '0;
			tt_q    <= '0;
			sq_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rr_q    <= rr_d;
			tt_q    <= tt_d;
			sq_q    <= sq_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		rr_d    = rr_q;
		tt_d    = tt_q;
		sq_d    = sq_q;
		cmd     = '0;
		cmd.rd_sel  = cnt_q[2:0];
		cmd.cap_sel = cnt_q[2:0] - 3'd1;
		cmd.mrow    = rr_q;
		cmd.mterm   = tt_q;
		cmd.msq     = sq_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					cnt_d = '0;
					if (kind) begin
						if (stat.drain_pending) begin
							state_d = S_LOAD;
						end
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd_en = (cnt_q < 5'd5);
				cmd.cap   = (cnt_q != 5'd0);
				if (cnt_q == 5'd5) begin
					cmd.wr = 1'b1;
					if (!stat.emit) begin
						state_d = S_IDLE;
					end else if (stat.zero) begin
						state_d = S_LOAD;
					end else begin
						state_d = S_DIFF;
					end
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				rr_d = '0;
				tt_d = '0;
				sq_d = 1'b0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (sq_q) begin
					if (rr_q == 2'd2) begin
						state_d = S_RINIT;
					end else begin
						rr_d = rr_q + 2'd1;
						state_d = S_MUL;
					end
				end else if (tt_q == 2'd2) begin
					state_d = S_RND;
				end else begin
					tt_d = tt_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				tt_d = '0;
				if (rr_q == 2'd2) begin
					rr_d = '0;
					sq_d = 1'b1;
				end else begin
					rr_d = rr_q + 2'd1;
				end
				state_d = S_MUL;
			end
			S_RINIT: begin
				cmd.root_init = 1'b1;
				cnt_d = '0;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == 5'(ROOT_STEPS - 1)) begin
					state_d = S_LOAD;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/vgm_datapath.sv
`timescale 1ns / 1ps
// vgm_datapath: configuration, position counters, plane store, shared
// multiplier, bit-serial square root and output register. Depends on vgm_pkg, vgm_ram.
module vgm_datapath import vgm_pkg::*; #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       kind,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  cmd_t                       cmd,
	output stat_t                      stat,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [GRAD_W-1:0]   grad_x,
	output logic signed [GRAD_W-1:0]   grad_y,
	output logic signed [GRAD_W-1:0]   grad_z,
	output logic [ROOT_W-1:0]          magnitude,
	output logic                       last
);

	localparam int PW  = MAX_X * MAX_Y;
	localparam int AW  = $clog2(2 * PW);
	localparam int XCW = $clog2(MAX_X);
	localparam int YCW = $clog2(MAX_Y);
	localparam int ZCW = $clog2(MAX_Z);
	localparam int DW  = $clog2(PW + 1);

	function automatic logic [31:0] clamp_size(logic [SIZE_W-1:0] v, int mx);
		logic [31:0] r;
		r = 32'(v);
		if (r < 32'd3) begin
			r = 32'd3;
		end else if (r > 32'(mx)) begin
			r = 32'(mx);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] addr_of(logic slot, logic [31:0] row, logic [31:0] col);
		logic [31:0] a;
		a = (slot ? 32'(PW) : 32'd0) + row * 32'(MAX_X) + col;
		return a[AW-1:0];
	endfunction

	// configuration
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [CFG_W-1:0]  coefs_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= 9'd256;
			size_y_q   <= 9'd256;
			size_z_q   <= 9'd256;
			coefs_q[0] <= 48'd4096;
			coefs_q[1] <= 48'd4096 << 16;
			coefs_q[2] <= 48'd4096 << 32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_X:   size_x_q   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y:   size_y_q   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z:   size_z_q   <= cfg_data[SIZE_W-1:0];
				REG_ROW_ZERO: coefs_q[0] <= cfg_data;
				REG_ROW_ONE:  coefs_q[1] <= cfg_data;
				REG_ROW_TWO:  coefs_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] sx, sy, sz;
	assign sx = clamp_size(size_x_q, MAX_X);
	assign sy = clamp_size(size_y_q, MAX_Y);
	assign sz = clamp_size(size_z_q, MAX_Z);

	// position and drain counters
	logic [XCW-1:0] col_q;
	logic [YCW-1:0] row_q;
	logic [ZCW-1:0] pl_q;
	logic [DW-1:0]  drain_q;
	logic           emit_q, zero_q, last_q;
	logic [31:0]    col_n, row_n, pl_n, area;
	logic           face;

	assign col_n = 32'(col_q) + 32'd1;
	assign row_n = 32'(row_q) + 32'd1;
	assign pl_n  = 32'(pl_q) + 32'd1;
	assign area  = sx * sy;
	assign face  = (col_q == '0) || (32'(col_q) >= sx - 32'd1) ||
	               (row_q == '0) || (32'(row_q) >= sy - 32'd1) ||
	               (32'(pl_q) == 32'd1) || (32'(pl_q) >= sz);

	wire voxel_acc = cmd.accept && !kind;
	wire drain_acc = cmd.accept && kind && (drain_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			pl_q    <= '0;
			drain_q <= '0;
			emit_q  <= 1'b0;
			zero_q  <= 1'b0;
			last_q  <= 1'b0;
		end else if (voxel_acc) begin
			drain_q <= '0;
			emit_q  <= (pl_q != '0);
			zero_q  <= face;
			last_q  <= 1'b0;
			if (col_n >= sx) begin
				col_q <= '0;
				if (row_n >= sy) begin
					row_q <= '0;
					if (pl_n >= sz) begin
						pl_q    <= '0;
						drain_q <= area[DW-1:0];
					end else begin
						pl_q <= pl_n[ZCW-1:0];
					end
				end else begin
					row_q <= row_n[YCW-1:0];
				end
			end else begin
				col_q <= col_n[XCW-1:0];
			end
		end else if (drain_acc) begin
			drain_q <= drain_q - DW'(1);
			zero_q  <= 1'b1;
			last_q  <= (drain_q == DW'(1));
		end
	end

	// transaction position and sample
	logic [XCW-1:0]              pcol_q;
	logic [YCW-1:0]              prow_q;
	logic                        pslot_q;
	logic signed [SAMPLE_W-1:0]  sample_q;

	always_ff @(posedge clk) begin
		if (voxel_acc) begin
			pcol_q   <= col_q;
			prow_q   <= row_q;
			pslot_q  <= pl_q[0];
			sample_q <= sample;
		end
	end

	// plane store
	logic [AW-1:0]       raddr, waddr;
	logic [SAMPLE_W-1:0] rdata;

	assign waddr = addr_of(pslot_q, 32'(prow_q), 32'(pcol_q));

	always_comb begin
		unique case (cmd.rd_sel)
			RD_OLD:  raddr = waddr;
			RD_XP:   raddr = addr_of(!pslot_q, 32'(prow_q), 32'(pcol_q) + 32'd1);
			RD_XM:   raddr = addr_of(!pslot_q, 32'(prow_q), 32'(pcol_q) - 32'd1);
			RD_YP:   raddr = addr_of(!pslot_q, 32'(prow_q) + 32'd1, 32'(pcol_q));
			RD_YM:   raddr = addr_of(!pslot_q, 32'(prow_q) - 32'd1, 32'(pcol_q));
			default: raddr = waddr;
		endcase
	end

	vgm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(2 * PW)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(waddr),
		.wdata(sample_q),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic signed [SAMPLE_W-1:0] old_q, xp_q, xm_q, yp_q, ym_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			unique case (cmd.cap_sel)
				RD_OLD:  old_q <= rdata;
				RD_XP:   xp_q  <= rdata;
				RD_XM:   xm_q  <= rdata;
				RD_YP:   yp_q  <= rdata;
				RD_YM:   ym_q  <= rdata;
				default: ;
			endcase
		end
	end

	// differences, shared multiplier and accumulator
	logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic signed [G_W-1:0]    g_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [MUL_W-1:0]  op_a, op_b;
	logic [CFG_W-1:0]         crow;
	logic signed [ACC_W-1:0]  rnd_t;

	assign crow  = coefs_q[cmd.mrow];
	assign rnd_t = acc_q + ACC_W'(4096);

	always_comb begin
		if (cmd.msq) begin
			op_a = g_q[cmd.mrow];
			op_b = g_q[cmd.mrow];
		end else begin
			unique case (cmd.mterm)
				2'd0: begin
					op_a = MUL_W'($signed(crow[15:0]));
					op_b = MUL_W'(dx_q);
				end
				2'd1: begin
					op_a = MUL_W'($signed(crow[31:16]));
					op_b = MUL_W'(dy_q);
				end
				2'd2: begin
					op_a = MUL_W'($signed(crow[47:32]));
					op_b = MUL_W'(dz_q);
				end
				default: begin
					op_a = '0;
					op_b = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dx_q  <= DIFF_W'(xp_q) - DIFF_W'(xm_q);
			dy_q  <= DIFF_W'(yp_q) - DIFF_W'(ym_q);
			dz_q  <= DIFF_W'(sample_q) - DIFF_W'(old_q);
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end else if (cmd.rnd) begin
			acc_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.rnd) begin
			g_q[cmd.mrow] <= rnd_t[13 +: G_W];
		end
	end

	// square root, one result bit a step
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q, rem_c, trial;
	logic [ROOT_W-1:0] root_q;

	assign rem_c = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rad_q  <= RAD_W'($unsigned(acc_q));
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_c >= trial) begin
				rem_q  <= rem_c - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_c;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last <= last_q;
			if (zero_q) begin
				grad_x    <= '0;
				grad_y    <= '0;
				grad_z    <= '0;
				magnitude <= '0;
			end else begin
				grad_x    <= GRAD_W'(g_q[0]);
				grad_y    <= GRAD_W'(g_q[1]);
				grad_z    <= GRAD_W'(g_q[2]);
				magnitude <= root_q;
			end
		end
	end

	assign stat.drain_pending = (drain_q != '0);
	assign stat.emit          = emit_q;
	assign stat.zero          = zero_q;
	assign stat.out_free      = !out_valid || out_ready;

endmodule

// File: bench/volume_gradient_magnitude_3d_test.sv
`timescale 1ns / 1ps
// volume_gradient_magnitude_3d_test: self-checking bench for the 3d gradient block.
// Streams volumes of voxels and drains, predicts every result and checks it.
// Depends on vgm_pkg and volume_gradient_magnitude_3d.
module volume_gradient_magnitude_3d_test;
	import vgm_pkg::*;

	localparam int MAX_DIM = 256;
	localparam int PLANE_WORDS = MAX_DIM * MAX_DIM;
	localparam logic KIND_VOXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic signed [GRAD_W-1:0] gz;
		logic [ROOT_W-1:0]        mag;
		logic                     last;
	} grad_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       kind;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [GRAD_W-1:0]   grad_x;
	logic signed [GRAD_W-1:0]   grad_y;
	logic signed [GRAD_W-1:0]   grad_z;
	logic [ROOT_W-1:0]          magnitude;
	logic                       last;

	// predictor state
	logic signed [SAMPLE_W-1:0] plane_mem [0:2*PLANE_WORDS-1];
	int unsigned vox_col, vox_row, vox_plane, drain_left;
	logic [SIZE_W-1:0] dim_reg [0:2];
	logic [CFG_W-1:0]  coef_row [0:2];
	grad_result_t      pending_results [$];

	int errors, items_sent, results_checked, volumes_sent;
	int idle_pct, stall_pct, hold_req;
	int hold_left;

	volume_gradient_magnitude_3d u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.sample(sample), .out_valid(out_valid), .out_ready(out_ready),
		.grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z), .magnitude(magnitude),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_size(logic [SIZE_W-1:0] v);
		if (v < 3) return 3;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic longint stored(int unsigned slot, int unsigned r, int unsigned c);
		return plane_mem[(slot & 1) * PLANE_WORDS + (r % MAX_DIM) * MAX_DIM + (c % MAX_DIM)];
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic predict_gradient(input logic k, input logic signed [SAMPLE_W-1:0] s);
		int unsigned sx, sy, sz, addr, prev;
		longint older, dx, dy, dz, acc, g;
		longint unsigned ssq, m;
		bit face;
		grad_result_t res;
		sx = eff_size(dim_reg[0]);
		sy = eff_size(dim_reg[1]);
		sz = eff_size(dim_reg[2]);
		res = '{default: '0};
		if (k == KIND_DRAIN) begin
			if (drain_left == 0) return;
			drain_left--;
			res.last = (drain_left == 0);
			pending_results.push_back(res);
			return;
		end
		drain_left = 0;
		addr = (vox_plane & 1) * PLANE_WORDS + (vox_row % MAX_DIM) * MAX_DIM
			+ (vox_col % MAX_DIM);
		older = plane_mem[addr];
		plane_mem[addr] = s;
		if (vox_plane >= 1) begin
			face = vox_col == 0 || vox_col >= sx - 1 || vox_row == 0 || vox_row >= sy - 1
				|| vox_plane - 1 == 0 || vox_plane - 1 >= sz - 1;
			if (!face) begin
				prev = (vox_plane + 1) & 1;
				dx = stored(prev, vox_row, vox_col + 1) - stored(prev, vox_row, vox_col - 1);
				dy = stored(prev, vox_row + 1, vox_col) - stored(prev, vox_row - 1, vox_col);
				dz = longint'(s) - older;
				ssq = 0;
				for (int r = 0; r < 3; r++) begin
					acc = longint'($signed(coef_row[r][15:0])) * dx
						+ longint'($signed(coef_row[r][31:16])) * dy
						+ longint'($signed(coef_row[r][47:32])) * dz;
					g = (acc + 4096) >>> 13;
					if (g > 8388607) g = 8388607;
					if (g < -8388608) g = -8388608;
					ssq += longint'(g < 0 ? -g : g) * longint'(g < 0 ? -g : g);
					if (r == 0) res.gx = g[GRAD_W-1:0];
					else if (r == 1) res.gy = g[GRAD_W-1:0];
					else res.gz = g[GRAD_W-1:0];
				end
				m = floor_root(ssq);
				res.mag = (m > 64'hFFFFFF) ? 24'hFFFFFF : m[ROOT_W-1:0];
			end
			pending_results.push_back(res);
		end
		vox_col++;
		if (vox_col >= sx) begin
			vox_col = 0;
			vox_row++;
			if (vox_row >= sy) begin
				vox_row = 0;
				vox_plane++;
				if (vox_plane >= sz) begin
					vox_plane = 0;
					drain_left = sx * sy;
				end
			end
		end
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
	endtask

	// receiver: checks each result and drives out_ready
	always @(posedge clk) begin
		grad_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = pending_results.pop_front();
				results_checked++;
				if (grad_x !== e.gx) report_mismatch("grad_x", grad_x, e.gx);
				if (grad_y !== e.gy) report_mismatch("grad_y", grad_y, e.gy);
				if (grad_z !== e.gz) report_mismatch("grad_z", grad_z, e.gz);
				if (magnitude !== e.mag) report_mismatch("magnitude", magnitude, e.mag);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_transaction(input logic k, input logic signed [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		predict_gradient(k, s);
		items_sent++;
	endtask

	// let the block go idle: every result in and the last silent voxel worked off
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SIZE_X: dim_reg[0] = val[SIZE_W-1:0];
			REG_SIZE_Y: dim_reg[1] = val[SIZE_W-1:0];
			REG_SIZE_Z: dim_reg[2] = val[SIZE_W-1:0];
			REG_ROW_ZERO: coef_row[0] = val;
			REG_ROW_ONE: coef_row[1] = val;
			REG_ROW_TWO: coef_row[2] = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
			input logic [CFG_W-1:0] sz, input logic [CFG_W-1:0] r0,
			input logic [CFG_W-1:0] r1, input logic [CFG_W-1:0] r2);
		settle();
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		write_reg(REG_ROW_ZERO, r0);
		write_reg(REG_ROW_ONE, r1);
		write_reg(REG_ROW_TWO, r2);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(11))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			2: return 16'sh0000;
			3: return -16'sh0001;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// extremes = 1 gives max-swing differences on every interior voxel of a volume three on a side
	task automatic send_volume(input bit extremes);
		int unsigned nx, ny, nz;
		nx = eff_size(dim_reg[0]);
		ny = eff_size(dim_reg[1]);
		nz = eff_size(dim_reg[2]);
		for (int unsigned z = 0; z < nz; z++)
			for (int unsigned y = 0; y < ny; y++)
				for (int unsigned x = 0; x < nx; x++)
					if (extremes)
						send_transaction(KIND_VOXEL, (x == nx - 1 || y == ny - 1
							|| z == nz - 1) ? 16'sh7fff : -16'sh8000);
					else
						send_transaction(KIND_VOXEL, pick_sample());
		volumes_sent++;
	endtask

	task automatic send_drains(input int n);
		for (int i = 0; i < n; i++) begin
			send_transaction(KIND_DRAIN, SAMPLE_W'($urandom));
		end
	endtask

	task automatic test_directed();
		configure(3, 3, 3, {3{16'h7fff}}, {3{16'h8000}}, {16'hffff, 16'h0000, 16'h1000});
		send_volume(1);
		send_drains(9);
		send_transaction(KIND_DRAIN, -16'sh0001);
		configure(4, 3, 5, 48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000);
		send_volume(0);
		send_drains(3);
		send_volume(0);
		send_drains(12);
	endtask

	task automatic test_size_clamps();
		configure(0, 1, 2, {pick_coef(), pick_coef(), pick_coef()},
			{pick_coef(), pick_coef(), pick_coef()}, {pick_coef(), pick_coef(), pick_coef()});
		send_volume(0);
		send_drains(9);
		// oversized row wraps at the maximum, then the volume goes on three wide
		configure(9'h1ff, 3, 3, 48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000);
		for (int i = 0; i < MAX_DIM; i++) send_transaction(KIND_VOXEL, pick_sample());
		configure(3, 3, 3, {pick_coef(), pick_coef(), pick_coef()},
			{pick_coef(), pick_coef(), pick_coef()}, {pick_coef(), pick_coef(), pick_coef()});
		for (int i = 0; i < 24; i++) send_transaction(KIND_VOXEL, pick_sample());
		volumes_sent++;
		send_drains(9);
	endtask

	task automatic test_random_phase(input int in_pct, input int out_pct, input int target);
		int start, n;
		idle_pct = in_pct;
		stall_pct = out_pct;
		start = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(2) == 0)
				configure(CFG_W'($urandom_range(3, ($urandom_range(3) == 0) ? 12 : 6)),
					CFG_W'($urandom_range(3, 6)), CFG_W'($urandom_range(3, 6)),
					{pick_coef(), pick_coef(), pick_coef()},
					{pick_coef(), pick_coef(), pick_coef()},
					{pick_coef(), pick_coef(), pick_coef()});
			send_volume(0);
			n = eff_size(dim_reg[0]) * eff_size(dim_reg[1]);
			case ($urandom_range(19))
				0, 1, 2: send_drains($urandom_range(1, n - 1));
				3, 4: ;
				5, 6, 7: send_drains(n + $urandom_range(1, 2));
				default: send_drains(n);
			endcase
		end
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		configure(5, 4, 4, {pick_coef(), pick_coef(), pick_coef()},
			{pick_coef(), pick_coef(), pick_coef()}, {pick_coef(), pick_coef(), pick_coef()});
		hold_req = 600;
		send_volume(0);
		send_drains(20);
		settle();
		send_volume(0);
		send_drains(20);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		sample = '0;
		out_ready = 1'b0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		volumes_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		vox_col = 0;
		vox_row = 0;
		vox_plane = 0;
		drain_left = 0;
		for (int i = 0; i < 3; i++) dim_reg[i] = 9'd256;
		coef_row[0] = 48'h0000_0000_1000;
		coef_row[1] = 48'h0000_1000_0000;
		coef_row[2] = 48'h1000_0000_0000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_clamps();
		test_random_phase(0, 0, 200);
		test_random_phase(47, 0, 200);
		test_random_phase(0, 47, 200);
		test_random_phase(13, 13, 200);
		test_backpressure();
		settle();
		$display("covered %0d volumes, %0d transactions sent, %0d results checked",
			volumes_sent, items_sent, results_checked);
		$display("size clamps, extreme matrices, partial and surplus drains, long stalls");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#30ms;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
